// File: design/tbb_pkg.sv
`timescale 1ns / 1ps

package tbb_pkg;

    localparam int AXES       = 3;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int GAINS_W    = AXES * GAIN_W;
    localparam int OFFSET_W   = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_LO = 3;

    localparam logic [GAINS_W-1:0] X_GAINS_RESET = 48'h0000_0000_1000;
    localparam logic [GAINS_W-1:0] Y_GAINS_RESET = 48'h0000_1000_0000;
    localparam logic [GAINS_W-1:0] Z_GAINS_RESET = 48'h1000_0000_0000;

    typedef enum logic [CFG_ADDR_W-CFG_IDX_LO-1:0] {
        REG_X_GAINS  = 3'd0,
        REG_Y_GAINS  = 3'd1,
        REG_Z_GAINS  = 3'd2,
        REG_X_OFFSET = 3'd3,
        REG_Y_OFFSET = 3'd4,
        REG_Z_OFFSET = 3'd5
    } cfg_reg_t;

endpackage

// File: design/transformed_bounding_box_unit.sv
`timescale 1ns / 1ps

// Axis-aligned bounding box of affine-transformed vertices.
// Input stream: one vertex per item on s_tdata (x, y, z in signed Q16.16),
// s_tlast marks the final vertex of a set. Each vertex goes through a 3x3
// Q4.12 gain matrix plus offset, rounded half up and saturated to COORD_WIDTH.
// Output stream: one item per set on m_tdata, low corner then high corner,
// sent after the vertex carrying s_tlast.
// Throughput: one vertex per cycle while s_tready is high. Pipeline: input
// register, nine 16 x COORD_WIDTH products, sum/round/saturate, corner update
// into the output register, which takes the result as the last vertex leaves.
// Stall: while a result waits on m_tready the pipeline keeps flowing until a
// further last vertex reaches the final stage; it holds there, the stages
// behind it fill and s_tready drops. Up to three vertices are then in flight.
// Config: APB, pready always high, registers at 8-byte steps (gains x/y/z, then
// offsets x/y/z); the user writes them only while the block is idle; not enforced.
// Reset (rst_n low, asynchronous): gains return to identity, offsets to zero,
// the pipeline and the output empty, the next vertex starts a new set.

module transformed_bounding_box_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // s_tdata: pos_x, pos_y, pos_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    input  logic                                      s_tlast,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // m_tdata: min_x, min_y, min_z, max_x, max_y, max_z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [tbb_pkg::CFG_ADDR_W-1:0]            paddr,
    input  logic [tbb_pkg::CFG_DATA_W-1:0]            pwdata,
    output logic [tbb_pkg::CFG_DATA_W-1:0]            prdata,
    output logic                                      pready
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = ((6*COORD_WIDTH+7)/8)*8;
    localparam int PROD_W = CW + tbb_pkg::GAIN_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = SUM_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(1 << (tbb_pkg::GAIN_FRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // configuration
    logic [tbb_pkg::GAINS_W-1:0]  gains_reg  [tbb_pkg::AXES];
    logic [tbb_pkg::OFFSET_W-1:0] offset_reg [tbb_pkg::AXES];
    logic                         cfg_wr;
    tbb_pkg::cfg_reg_t            cfg_idx;

    // pipeline
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                         s1_last_reg, s2_last_reg, s3_last_reg;
    logic signed [CW-1:0]         s1_pos_reg   [tbb_pkg::AXES];
    logic signed [PROD_W-1:0]     s2_prod_reg  [tbb_pkg::AXES][tbb_pkg::AXES];
    logic signed [PROD_W-1:0]     prod_next    [tbb_pkg::AXES][tbb_pkg::AXES];
    logic signed [CW-1:0]         s3_coord_reg [tbb_pkg::AXES];
    logic signed [CW-1:0]         coord_next   [tbb_pkg::AXES];

    logic                         started_reg;
    logic signed [CW-1:0]         low_reg   [tbb_pkg::AXES];
    logic signed [CW-1:0]         high_reg  [tbb_pkg::AXES];
    logic signed [CW-1:0]         low_next  [tbb_pkg::AXES];
    logic signed [CW-1:0]         high_next [tbb_pkg::AXES];

    logic                         out_valid_reg;
    logic signed [CW-1:0]         out_min_reg [tbb_pkg::AXES];
    logic signed [CW-1:0]         out_max_reg [tbb_pkg::AXES];

    logic                         s_fire, s1_go, s2_go, s3_go, out_free, close_set;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = tbb_pkg::cfg_reg_t'(paddr[tbb_pkg::CFG_ADDR_W-1:tbb_pkg::CFG_IDX_LO]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg[0]  <= tbb_pkg::X_GAINS_RESET;
            gains_reg[1]  <= tbb_pkg::Y_GAINS_RESET;
            gains_reg[2]  <= tbb_pkg::Z_GAINS_RESET;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                tbb_pkg::REG_X_GAINS:  gains_reg[0]  <= pwdata[tbb_pkg::GAINS_W-1:0];
                tbb_pkg::REG_Y_GAINS:  gains_reg[1]  <= pwdata[tbb_pkg::GAINS_W-1:0];
                tbb_pkg::REG_Z_GAINS:  gains_reg[2]  <= pwdata[tbb_pkg::GAINS_W-1:0];
                tbb_pkg::REG_X_OFFSET: offset_reg[0] <= pwdata[tbb_pkg::OFFSET_W-1:0];
                tbb_pkg::REG_Y_OFFSET: offset_reg[1] <= pwdata[tbb_pkg::OFFSET_W-1:0];
                tbb_pkg::REG_Z_OFFSET: offset_reg[2] <= pwdata[tbb_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            tbb_pkg::REG_X_GAINS:  prdata = tbb_pkg::CFG_DATA_W'(gains_reg[0]);
            tbb_pkg::REG_Y_GAINS:  prdata = tbb_pkg::CFG_DATA_W'(gains_reg[1]);
            tbb_pkg::REG_Z_GAINS:  prdata = tbb_pkg::CFG_DATA_W'(gains_reg[2]);
            tbb_pkg::REG_X_OFFSET: prdata = tbb_pkg::CFG_DATA_W'(offset_reg[0]);
            tbb_pkg::REG_Y_OFFSET: prdata = tbb_pkg::CFG_DATA_W'(offset_reg[1]);
            tbb_pkg::REG_Z_OFFSET: prdata = tbb_pkg::CFG_DATA_W'(offset_reg[2]);
            default:               prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign out_free  = !out_valid_reg || m_tready;
    assign s3_go     = s3_valid_reg && (!s3_last_reg || out_free);
    assign s2_go     = s2_valid_reg && (!s3_valid_reg || s3_go);
    assign s1_go     = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign s_tready  = !s1_valid_reg || s1_go;
    assign s_fire    = s_tvalid && s_tready;
    assign close_set = s3_go && s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s_fire || (s1_valid_reg && !s1_go);
            s2_valid_reg  <= s1_go  || (s2_valid_reg && !s2_go);
            s3_valid_reg  <= s2_go  || (s3_valid_reg && !s3_go);
            out_valid_reg <= close_set || (out_valid_reg && !m_tready);
            if (s3_go)
            begin
                started_reg <= !s3_last_reg;
            end
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        for (int a = 0; a < tbb_pkg::AXES; a++)
        begin
            for (int k = 0; k < tbb_pkg::AXES; k++)
            begin
                prod_next[a][k] =
                    $signed(gains_reg[a][k*tbb_pkg::GAIN_W +: tbb_pkg::GAIN_W])
                    * s1_pos_reg[k];
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] rounded;
        logic signed [ACC_W-1:0] acc;
        for (int a = 0; a < tbb_pkg::AXES; a++)
        begin
            sum = SUM_W'(s2_prod_reg[a][0]) + SUM_W'(s2_prod_reg[a][1])
                + SUM_W'(s2_prod_reg[a][2]) + ROUND_ADD;
            rounded = sum >>> tbb_pkg::GAIN_FRAC;
            acc = ACC_W'(rounded) + ACC_W'($signed(offset_reg[a]));
            if (acc > SAT_HI)
            begin
                coord_next[a] = SAT_HI[CW-1:0];
            end
            else if (acc < SAT_LO)
            begin
                coord_next[a] = SAT_LO[CW-1:0];
            end
            else
            begin
                coord_next[a] = acc[CW-1:0];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < tbb_pkg::AXES; a++)
        begin
            low_next[a]  = (!started_reg || s3_coord_reg[a] < low_reg[a])
                           ? s3_coord_reg[a] : low_reg[a];
            high_next[a] = (!started_reg || s3_coord_reg[a] > high_reg[a])
                           ? s3_coord_reg[a] : high_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            for (int k = 0; k < tbb_pkg::AXES; k++)
            begin
                s1_pos_reg[k] <= s_tdata[k*CW +: CW];
            end
            s1_last_reg <= s_tlast;
        end
        if (s1_go)
        begin
            s2_prod_reg <= prod_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_go)
        begin
            s3_coord_reg <= coord_next;
            s3_last_reg  <= s2_last_reg;
        end
        if (s3_go)
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
        if (close_set)
        begin
            out_min_reg <= low_next;
            out_max_reg <= high_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_max_reg[2], out_max_reg[1], out_max_reg[0],
                              out_min_reg[2], out_min_reg[1], out_min_reg[0]});

`ifndef SYNTH
    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_min_reg[0] <= out_max_reg[0]) &&
                          (out_min_reg[1] <= out_max_reg[1]) &&
                          (out_min_reg[2] <= out_max_reg[2]))
        else $error("bounding box corners out of order");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
        close_set |=> !started_reg && out_valid_reg)
        else $error("set not closed after last vertex");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(close_set))
        else $error("result without a last vertex");
`endif

endmodule
